>>> hdl/mslfo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mslfo_pkg: shared types, constants and tables
// Widths, shape and register codes, the quarter-wave sine table and the
// noise level table for the multi-shape LFO.
// ----------------------------------------------------------------------------
package mslfo_pkg;

	localparam int PHASE_BITS       = 32;
	localparam int SINE_TABLE_DEPTH = 256;
	localparam int SINE_IDX_BITS    = $clog2(SINE_TABLE_DEPTH);
	localparam int SINE_ENTRY_BITS  = 16;
	localparam int FRAME_BITS       = 12;
	localparam int RATE_BITS        = 32;
	localparam int PROD_BITS        = FRAME_BITS + RATE_BITS;
	localparam int FRAC_BITS        = 32;
	localparam int WAVE_BITS        = 17;
	localparam int SHAPE_BITS       = 4;
	localparam int CFG_INDEX_BITS   = 3;
	localparam int CFG_DATA_BITS    = 32;

	localparam int               LFSR_BITS = 16;
	localparam logic [LFSR_BITS-1:0] LFSR_SEED = 16'hACE1;
	localparam logic [LFSR_BITS-1:0] LFSR_TAPS = 16'hB400;

	// noise level: lfsr mod 100, by reciprocal multiply (exact for 16-bit values)
	localparam int NOISE_LEVELS     = 100;
	localparam int NOISE_N_BITS     = $clog2(NOISE_LEVELS);
	localparam int NOISE_RECIP      = 83887;
	localparam int NOISE_RECIP_BITS = 17;
	localparam int NOISE_SHIFT      = 23;
	localparam int NOISE_Q_BITS     = LFSR_BITS + NOISE_RECIP_BITS - NOISE_SHIFT;
	localparam int NOISE_VAL_BITS   = 15;

	localparam logic signed [WAVE_BITS-1:0] WAVE_ONE  = 17'sd32768;
	localparam logic signed [WAVE_BITS-1:0] WAVE_ZERO = 17'sd0;
	localparam logic signed [WAVE_BITS-1:0] STEP4_A   = 17'sd8192;
	localparam logic signed [WAVE_BITS-1:0] STEP4_D   = -17'sd8192;
	localparam logic signed [WAVE_BITS-1:0] STEP4P_A  = 17'sd21845;
	localparam logic signed [WAVE_BITS-1:0] STEP4P_D  = 17'sd10923;
	localparam logic signed [WAVE_BITS-1:0] STEP3_C   = 17'sd16384;
	localparam logic [FRAC_BITS+1:0]        STEP3_BIAS = 34'd4294537800;

	typedef enum logic [SHAPE_BITS-1:0] {
		SHAPE_SINE      = 4'd0,
		SHAPE_NONE      = 4'd1,
		SHAPE_SINE_POS  = 4'd2,
		SHAPE_TRI       = 4'd3,
		SHAPE_TRI_POS   = 4'd4,
		SHAPE_SQ        = 4'd5,
		SHAPE_SQ_POS    = 4'd6,
		SHAPE_SAW_RISE  = 4'd7,
		SHAPE_SAW_FALL  = 4'd8,
		SHAPE_STEP4     = 4'd9,
		SHAPE_STEP4_POS = 4'd10,
		SHAPE_STEP3_POS = 4'd11,
		SHAPE_RANDOM    = 4'd12
	} shape_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_WAVE_SHAPE  = 3'd0,
		REG_RATE_SLOW   = 3'd1,
		REG_RATE_FAST   = 3'd2,
		REG_FAST_SELECT = 3'd3,
		REG_START_PHASE = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [SHAPE_BITS-1:0] wave_shape;
		logic [RATE_BITS-1:0]  rate_slow;
		logic [RATE_BITS-1:0]  rate_fast;
		logic                  fast_select;
		logic [FRAC_BITS-1:0]  start_phase;
	} cfg_t;

	// word handed from the phase stage to the waveform stage
	typedef struct packed {
		logic [FRAC_BITS-1:0]    phase_u;
		shape_t                  shape;
		logic [NOISE_N_BITS-1:0] noise_n;
	} stage_t;

	typedef logic [SINE_ENTRY_BITS-1:0] sine_rom_t [SINE_TABLE_DEPTH];
	typedef logic [NOISE_VAL_BITS-1:0]  noise_rom_t [NOISE_LEVELS];

	// round(32768*sin(pi/2*i/D)) from a Q30 Taylor series
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t          rom;
		logic [63:0]        a;
		logic [63:0]        a2;
		logic [63:0]        term;
		logic signed [63:0] s;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			a    = (64'(i) * 64'd1686629713) / SINE_TABLE_DEPTH;
			a2   = (a * a) >> 30;
			term = a;
			s    = $signed(a);
			term = ((term * a2) >> 30) / 6;
			s    = s - $signed(term);
			term = ((term * a2) >> 30) / 20;
			s    = s + $signed(term);
			term = ((term * a2) >> 30) / 42;
			s    = s - $signed(term);
			term = ((term * a2) >> 30) / 72;
			s    = s + $signed(term);
			term = ((term * a2) >> 30) / 110;
			s    = s - $signed(term);
			term = ((term * a2) >> 30) / 156;
			s    = s + $signed(term);
			if (s < 0)
				s = '0;
			rom[i] = SINE_ENTRY_BITS'((s + 64'sd16384) >>> 15);
		end
		return rom;
	endfunction

	// round(n*32768/100)
	function automatic noise_rom_t build_noise_rom();
		noise_rom_t rom;
		for (int n = 0; n < NOISE_LEVELS; n++)
			rom[n] = NOISE_VAL_BITS'((n * 32768 + NOISE_LEVELS / 2) / NOISE_LEVELS);
		return rom;
	endfunction

	localparam sine_rom_t  SINE_ROM  = build_sine_rom();
	localparam noise_rom_t NOISE_ROM = build_noise_rom();

	// top 32 bits of the phase as a fraction of a cycle
	function automatic logic [FRAC_BITS-1:0] phase_frac(input logic [PHASE_BITS-1:0] ph);
		logic [PHASE_BITS+FRAC_BITS-1:0] wide;
		wide = {ph, {FRAC_BITS{1'b0}}} >> PHASE_BITS;
		return wide[FRAC_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

>>> hdl/mslfo_cmd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mslfo_cmd_if: command channel
// Tick or key-on word with its frame count, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mslfo_cmd_if;
	import mslfo_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  mode;
	logic [FRAME_BITS-1:0] frame_count;

	modport source (output valid, output mode, output frame_count, input ready);
	modport sink   (input valid, input mode, input frame_count, output ready);
endinterface
`default_nettype wire

>>> hdl/mslfo_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mslfo_res_if: result channel
// Signed waveform value word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mslfo_res_if;
	import mslfo_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [WAVE_BITS-1:0] wave_value;

	modport source (output valid, output wave_value, input ready);
	modport sink   (input valid, input wave_value, output ready);
endinterface
`default_nettype wire

>>> hdl/mslfo_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mslfo_cfg: configuration registers
// Write-only register file; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module mslfo_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mslfo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [mslfo_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	output mslfo_pkg::cfg_t                      cfg
);
	import mslfo_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WAVE_SHAPE:  cfg_q.wave_shape  <= cfg_wdata[SHAPE_BITS-1:0];
				REG_RATE_SLOW:   cfg_q.rate_slow   <= cfg_wdata[RATE_BITS-1:0];
				REG_RATE_FAST:   cfg_q.rate_fast   <= cfg_wdata[RATE_BITS-1:0];
				REG_FAST_SELECT: cfg_q.fast_select <= cfg_wdata[0];
				REG_START_PHASE: cfg_q.start_phase <= cfg_wdata[FRAC_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

>>> hdl/mslfo_phase.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mslfo_phase: input stage
// Latches shape and rate choice on key on; on ticks advances the phase and,
// if random, the noise LFSR, and registers the word for the waveform stage.
// ----------------------------------------------------------------------------
module mslfo_phase (
	input  logic              clk,
	input  logic              arst_n,
	input  mslfo_pkg::cfg_t   cfg,
	mslfo_cmd_if.sink         cmd,
	input  logic              s2_ready,
	output logic              valid_s1,
	output mslfo_pkg::stage_t data_s1
);
	import mslfo_pkg::*;

	logic [PHASE_BITS-1:0]       phase_q;
	shape_t                      shape_q;
	logic                        fast_q;
	logic [LFSR_BITS-1:0]        lfsr_q;

	logic                        take;
	logic                        tick;
	logic                        keyon;
	logic                        is_random;
	logic [RATE_BITS-1:0]        rate;
	logic [PROD_BITS-1:0]        prod;
	logic [PHASE_BITS-1:0]       phase_next;
	logic [LFSR_BITS-1:0]        lfsr_next;
	logic [LFSR_BITS+NOISE_RECIP_BITS-1:0] recip_prod;
	logic [NOISE_Q_BITS-1:0]     noise_q;
	logic [LFSR_BITS-1:0]        noise_qx;
	logic [LFSR_BITS-1:0]        noise_rem;

	assign cmd.ready = !valid_s1 || s2_ready;
	assign take      = cmd.valid && cmd.ready;
	assign tick      = take && !cmd.mode;
	assign keyon     = take && cmd.mode;
	assign is_random = shape_q >= SHAPE_RANDOM;

	always_comb begin
		rate       = fast_q ? cfg.rate_fast : cfg.rate_slow;
		prod       = PROD_BITS'(cmd.frame_count) * PROD_BITS'(rate);
		phase_next = phase_q + PHASE_BITS'(prod);

		lfsr_next = lfsr_q >> 1;
		if (lfsr_q[0])
			lfsr_next = lfsr_next ^ LFSR_TAPS;

		// remainder by 100 via reciprocal, no correction needed over 16 bits
		recip_prod = (LFSR_BITS + NOISE_RECIP_BITS)'(lfsr_next)
			* (LFSR_BITS + NOISE_RECIP_BITS)'(NOISE_RECIP);
		noise_q    = recip_prod[LFSR_BITS+NOISE_RECIP_BITS-1:NOISE_SHIFT];
		noise_qx   = LFSR_BITS'(LFSR_BITS'(noise_q) * LFSR_BITS'(NOISE_LEVELS));
		noise_rem  = lfsr_next - noise_qx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			shape_q  <= SHAPE_NONE;
			fast_q   <= 1'b0;
			lfsr_q   <= LFSR_SEED;
			valid_s1 <= 1'b0;
		end else begin
			if (keyon) begin
				shape_q <= shape_t'(cfg.wave_shape);
				fast_q  <= cfg.fast_select;
				phase_q <= PHASE_BITS'(cfg.start_phase);
			end
			if (tick) begin
				phase_q <= phase_next;
				if (is_random)
					lfsr_q <= lfsr_next;
			end
			if (cmd.ready)
				valid_s1 <= tick;
		end
	end

	// snapshot the shape so a later key on cannot touch this word
	always_ff @(posedge clk) begin
		if (tick) begin
			data_s1.phase_u <= phase_frac(phase_next);
			data_s1.shape   <= shape_q;
			data_s1.noise_n <= noise_rem[NOISE_N_BITS-1:0];
		end
	end

endmodule
`default_nettype wire

>>> hdl/mslfo_wave.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mslfo_wave: waveform stage
// Maps the phase to the selected shape and holds the result word until taken.
// ----------------------------------------------------------------------------
module mslfo_wave (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  mslfo_pkg::stage_t data_s1,
	output logic              s2_ready,
	mslfo_res_if.source       res
);
	import mslfo_pkg::*;

	logic                        valid_s2;
	logic signed [WAVE_BITS-1:0] wave_s2;

	logic [FRAC_BITS-1:0]        u;
	logic [SINE_IDX_BITS-1:0]    idx;
	logic [SINE_IDX_BITS-1:0]    rom_addr;
	logic [WAVE_BITS-1:0]        mag;
	logic signed [WAVE_BITS-1:0] sine;
	logic signed [WAVE_BITS:0]   sine_sum;
	logic [WAVE_BITS-1:0]        u17;
	logic [WAVE_BITS-1:0]        d17;
	logic signed [WAVE_BITS:0]   tri_wide;
	logic [WAVE_BITS-1:0]        u16x;
	logic [FRAC_BITS+1:0]        step3_sum;
	logic signed [WAVE_BITS-1:0] wave_d;

	always_comb begin
		u = data_s1.phase_u;

		// sine: odd quadrants mirror the index, index zero there is the peak
		idx      = u[FRAC_BITS-3 -: SINE_IDX_BITS];
		rom_addr = u[FRAC_BITS-2] ? (~idx + 1'b1) : idx;
		if (u[FRAC_BITS-2] && idx == '0)
			mag = WAVE_ONE;
		else
			mag = WAVE_BITS'(SINE_ROM[rom_addr]);
		sine     = u[FRAC_BITS-1] ? -$signed(mag) : $signed(mag);
		sine_sum = (WAVE_BITS+1)'(sine) + (WAVE_BITS+1)'(WAVE_ONE);

		u17      = u[FRAC_BITS-1 -: WAVE_BITS];
		d17      = u17[WAVE_BITS-1] ? {1'b0, u17[WAVE_BITS-2:0]}
			: WAVE_BITS'(18'd65536 - {1'b0, u17});
		tri_wide = $signed({1'b0, d17}) - $signed((WAVE_BITS+1)'(WAVE_ONE));

		u16x = {1'b0, u[FRAC_BITS-1 -: WAVE_BITS-1]};

		step3_sum = {2'b00, u} + {1'b0, u, 1'b0} + STEP3_BIAS;

		unique case (data_s1.shape)
			SHAPE_SINE:     wave_d = sine;
			SHAPE_NONE:     wave_d = WAVE_ZERO;
			SHAPE_SINE_POS: wave_d = WAVE_BITS'(sine_sum >>> 1);
			SHAPE_TRI:      wave_d = WAVE_BITS'(tri_wide);
			SHAPE_TRI_POS:  wave_d = $signed({1'b0, d17[WAVE_BITS-1:1]});
			SHAPE_SQ:       wave_d = u[FRAC_BITS-1] ? -WAVE_ONE : WAVE_ONE;
			SHAPE_SQ_POS:   wave_d = u[FRAC_BITS-1] ? WAVE_ZERO : WAVE_ONE;
			SHAPE_SAW_RISE: wave_d = $signed(u16x) - WAVE_ONE;
			SHAPE_SAW_FALL: wave_d = WAVE_ONE - $signed(u16x);
			SHAPE_STEP4: begin
				unique case (u[FRAC_BITS-1 -: 2])
					2'd0:    wave_d = STEP4_A;
					2'd1:    wave_d = WAVE_ONE;
					2'd2:    wave_d = -WAVE_ONE;
					default: wave_d = STEP4_D;
				endcase
			end
			SHAPE_STEP4_POS: begin
				unique case (u[FRAC_BITS-1 -: 2])
					2'd0:    wave_d = STEP4P_A;
					2'd1:    wave_d = WAVE_ONE;
					2'd2:    wave_d = WAVE_ZERO;
					default: wave_d = STEP4P_D;
				endcase
			end
			SHAPE_STEP3_POS: begin
				// top bits run 0..3; 3 folds back to 0
				unique case (step3_sum[FRAC_BITS+1 -: 2])
					2'd1:    wave_d = WAVE_ZERO;
					2'd2:    wave_d = STEP3_C;
					default: wave_d = WAVE_ONE;
				endcase
			end
			default:        wave_d = $signed(WAVE_BITS'(NOISE_ROM[data_s1.noise_n]));
		endcase
	end

	assign s2_ready = !valid_s2 || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1)
			wave_s2 <= wave_d;
	end

	assign res.valid      = valid_s2;
	assign res.wave_value = wave_s2;

endmodule
`default_nettype wire

>>> hdl/multi_shape_lfo_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_shape_lfo_core: thirteen-shape low-frequency oscillator
// Phase accumulator with sine, triangle, square, saw, step and noise shapes.
// ----------------------------------------------------------------------------
// Usage: a key-on word (mode 1) latches the shape and fast/slow choice from
// the configuration registers and loads the start phase; it returns nothing.
// A tick word (mode 0) advances the phase by frame_count times the selected
// rate, which is read live from its register, and returns one signed value
// in units of 1/32768. Before the first key on the shape is none and the
// result is zero. The block takes one word per clock unless the phase and
// waveform registers are full and the result side holds off. A tick's result
// passes through the phase register, which the accepting edge loads (one
// 12x32 multiply-add), then the waveform register (table lookup and select),
// which loads once it is free, and is presented from the waveform register.
// When the result side holds off, the two registers fill and input ready then
// follows result ready in the same cycle.
module multi_shape_lfo_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mslfo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [mslfo_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	mslfo_cmd_if.sink                            cmd,
	mslfo_res_if.source                          res
);
	import mslfo_pkg::*;

	cfg_t   cfg;
	logic   valid_s1;
	stage_t data_s1;
	logic   s2_ready;

	mslfo_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mslfo_phase u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.s2_ready (s2_ready),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	mslfo_wave u_wave (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.s2_ready (s2_ready),
		.res      (res)
	);

endmodule
`default_nettype wire
